### rtl/brightness_histogram_valley_finder_top_macros.svh
// Assertion macros for the brightness histogram valley finder.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BRIGHTNESS_HISTOGRAM_VALLEY_FINDER_TOP_MACROS_SVH
`define BRIGHTNESS_HISTOGRAM_VALLEY_FINDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define BHVF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bhvf assertion failed");
// Next-cycle implication, checked out of reset
`define BHVF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bhvf assertion failed");
`else
`define BHVF_ASSERT_IMP(lbl, ante, cons)
`define BHVF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/bhvf_pkg.sv
// Shared constants and types of the brightness histogram valley finder.
// No dependencies; imported by every module of the block but bhvf_ram.
package bhvf_pkg;

  localparam int unsigned NUM_BINS     = 256;
  localparam int unsigned BIN_W        = 8;
  localparam int unsigned COLOR_W      = 8;
  localparam int unsigned SUM_W        = 10;
  localparam int unsigned FIELD_W      = 24;
  localparam int unsigned WIN_W        = 6;
  localparam int unsigned COUNT_BITS_DEF = 24;
  localparam int unsigned STEP_W       = WIN_W + 1;

  // Upper bin limit for a valley center plus its upper window
  localparam int unsigned LAST_CENTER  = 254;

  // Divide by three: floor(sum * 683 / 2048) is exact for sums up to 765
  localparam int unsigned DIV3_MUL     = 683;
  localparam int unsigned DIV3_SHIFT   = 11;
  localparam int unsigned PROD_W       = 20;

  localparam logic [WIN_W-1:0] WIN_RESET = 6'd5;

  // APB register index (paddr[2])
  localparam logic REG_WINDOW = 1'b0;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Query sequencer states, one-hot
  typedef enum logic [3:0] {
    Q_IDLE   = 4'b0001,
    Q_CENTER = 4'b0010,
    Q_NBR    = 4'b0100,
    Q_DONE   = 4'b1000
  } q_state_e;

  // Read request into the histogram store
  typedef struct packed {
    logic             en;
    logic [BIN_W-1:0] addr;
  } rd_req_t;

  // Query sequencer status toward the output register
  typedef struct packed {
    logic done;
    logic valley;
  } q_status_t;

endpackage

### rtl/brightness_histogram_valley_finder_top.sv
// Top level of the brightness histogram valley finder: stream channels,
// APB register, pixel update stage and result register.
// Depends on bhvf_pkg, bhvf_store, bhvf_query and the macros header.
//
// Usage:
//   Items enter on s_axis (tuser = kind, tdata = red, green, blue, query_bin).
//   A pixel item adds one, saturating, to bin (r+g+b)/3; pixels stream at one
//   item per cycle while no query is busy, through a read, increment and
//   write-back of the bin RAM with forwarding between back-to-back hits.
//   A clear item zeroes all bins at once by dropping the per-bin valid bits.
//   A query item yields one result item on m_axis (tdata = bin_count,
//   valley_value; tuser = is_valley) once the query unit has read the center bin
//   and then, for a bin inside the window range, one neighbor bin per cycle from
//   the single RAM read port. s_axis_tready is low until the result is loaded,
//   so the next item can be taken in the same cycle that m_axis_tvalid rises at
//   the earliest. The result waits in an output register while m_axis_tready
//   is low; pixel and clear items are still taken meanwhile, a further query
//   stalls at its end. Reset empties the histogram and sets window_size to 5;
//   no clearing pass. window_size is written over APB at byte address 0.
`include "brightness_histogram_valley_finder_top_macros.svh"
module brightness_histogram_valley_finder_top #(
  parameter int unsigned COUNT_BITS = bhvf_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], query_bin[31:24]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // bin_count[23:0], valley_value[47:24]
  output logic        m_axis_tuser,   // is_valley[0]
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bhvf_pkg::*;

  localparam int unsigned WideW = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;
  localparam logic [WideW-1:0] FieldMax = WideW'({FIELD_W{1'b1}});

  kind_e                kind;
  logic                 in_acc;
  logic [COLOR_W-1:0]   red, green, blue, query_bin;
  logic [SUM_W-1:0]     px_sum;
  logic [PROD_W-1:0]    px_prod;
  logic [BIN_W-1:0]     px_bin;
  logic                 px_vld_q;
  logic [BIN_W-1:0]     px_addr_q;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] px_next;
  rd_req_t              px_req, q_req, rd_req;
  logic                 q_busy;
  q_status_t            q_status;
  logic [COUNT_BITS-1:0] q_count;
  logic [WideW-1:0]     count_wide;
  logic [FIELD_W-1:0]   count_clip;
  logic                 out_load;
  logic                 out_valid_q;
  logic [FIELD_W-1:0]   out_count_q, out_valley_q;
  logic                 out_flag_q;
  logic [WIN_W-1:0]     win_q;
  logic                 cfg_wr;

  // Unpack the input item
  assign kind      = kind_e'(s_axis_tuser);
  assign red       = s_axis_tdata[7:0];
  assign green     = s_axis_tdata[15:8];
  assign blue      = s_axis_tdata[23:16];
  assign query_bin = s_axis_tdata[31:24];
  assign s_axis_tready = !q_busy;
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  // Brightness bin by reciprocal multiply
  assign px_sum  = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
  assign px_prod = PROD_W'(px_sum) * PROD_W'(DIV3_MUL);
  assign px_bin  = px_prod[DIV3_SHIFT +: BIN_W];

  assign px_req.en   = in_acc && (kind == KIND_PIXEL);
  assign px_req.addr = px_bin;
  assign rd_req      = q_req.en ? q_req : px_req;

  // Pixel write-back stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_vld_q <= 1'b0;
    end else begin
      px_vld_q <= px_req.en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (px_req.en) begin
      px_addr_q <= px_bin;
    end
  end

  // Saturating increment
  assign px_next = (rd_data == {COUNT_BITS{1'b1}}) ? rd_data : rd_data + 1'b1;

  bhvf_store #(
    .CountBits(COUNT_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_req_i (rd_req),
    .wr_en_i  (px_vld_q),
    .wr_addr_i(px_addr_q),
    .wr_data_i(px_next),
    .clr_i    (in_acc && (kind == KIND_CLEAR)),
    .rd_data_o(rd_data)
  );

  bhvf_query #(
    .CountBits(COUNT_BITS)
  ) u_query (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc && (kind == KIND_QUERY)),
    .bin_i    (query_bin),
    .win_i    (win_q),
    .rd_data_i(rd_data),
    .take_i   (out_load),
    .rd_req_o (q_req),
    .busy_o   (q_busy),
    .status_o (q_status),
    .count_o  (q_count)
  );

  // Clip the count to the field width
  assign count_wide = WideW'(q_count);
  assign count_clip = (count_wide > FieldMax) ? {FIELD_W{1'b1}} : count_wide[FIELD_W-1:0];

  // Output register
  assign out_load = q_status.done && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q  <= count_clip;
      out_valley_q <= q_status.valley ? count_clip : '0;
      out_flag_q   <= q_status.valley;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_valley_q, out_count_q};
  assign m_axis_tuser  = out_flag_q;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
    end else if (cfg_wr) begin
      win_q <= pwdata[WIN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW) ? {{(32 - WIN_W){1'b0}}, win_q} : '0;

  // Checks
  `BHVF_ASSERT_IMP(a_valley_count, m_axis_tvalid && m_axis_tuser, m_axis_tdata[47:24] == m_axis_tdata[23:0])
  `BHVF_ASSERT_IMP(a_no_valley_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[47:24] == '0)
  `BHVF_ASSERT_NXT(a_query_blocks, in_acc && (kind == KIND_QUERY), !s_axis_tready)
  `BHVF_ASSERT_IMP(a_port_exclusive, px_vld_q, !q_req.en)

endmodule

### rtl/bhvf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bhvf_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bhvf_store.sv
// Histogram store: bin RAM plus per-bin valid bits that clear all bins at once,
// and a write-to-read forward. Depends on bhvf_pkg and bhvf_ram.
module bhvf_store #(
  parameter int unsigned CountBits = bhvf_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bhvf_pkg::rd_req_t        rd_req_i,
  input  logic                     wr_en_i,
  input  logic [bhvf_pkg::BIN_W-1:0] wr_addr_i,
  input  logic [CountBits-1:0]     wr_data_i,
  input  logic                     clr_i,
  output logic [CountBits-1:0]     rd_data_o
);
  import bhvf_pkg::*;

  logic [NUM_BINS-1:0]  valid_q;
  logic                 fwd_hit_q;
  logic [CountBits-1:0] fwd_data_q;
  logic [BIN_W-1:0]     rd_addr_q;
  logic [CountBits-1:0] ram_rdata;

  bhvf_ram #(
    .Width(CountBits),
    .Depth(NUM_BINS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_data_i),
    .re_i   (rd_req_i.en),
    .raddr_i(rd_req_i.addr),
    .rdata_o(ram_rdata)
  );

  // Valid bits: clear drops all at once and wins over a concurrent write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_i) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Catch a write landing on the entry being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_req_i.en) begin
      fwd_hit_q <= wr_en_i && (wr_addr_i == rd_req_i.addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      fwd_data_q <= wr_data_i;
      rd_addr_q  <= rd_req_i.addr;
    end
  end

  // Forwarded value first, then RAM data masked by the valid bit
  always_comb begin
    if (fwd_hit_q) begin
      rd_data_o = fwd_data_q;
    end else if (valid_q[rd_addr_q]) begin
      rd_data_o = ram_rdata;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

### rtl/bhvf_query.sv
// Query sequencer: reads the queried bin, then its neighbors one per cycle,
// and decides whether the bin is a strict valley. Depends on bhvf_pkg.
module bhvf_query #(
  parameter int unsigned CountBits = bhvf_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bhvf_pkg::BIN_W-1:0] bin_i,
  input  logic [bhvf_pkg::WIN_W-1:0] win_i,
  input  logic [CountBits-1:0]       rd_data_i,
  input  logic                       take_i,
  output bhvf_pkg::rd_req_t          rd_req_o,
  output logic                       busy_o,
  output bhvf_pkg::q_status_t        status_o,
  output logic [CountBits-1:0]       count_o
);
  import bhvf_pkg::*;

  q_state_e             state_q, state_d;
  logic [BIN_W-1:0]     bin_q;
  logic [CountBits-1:0] center_q;
  logic [STEP_W-1:0]    step_q, step_d;
  logic                 fail_q, fail_d;
  logic                 nbr_pend_q, nbr_pend_d;
  logic                 ctr_pend_q, ctr_pend_d;
  logic                 in_range;
  logic [STEP_W-1:0]    total;
  logic [BIN_W-1:0]     nbr_off;
  logic [BIN_W:0]       hi_sum;

  // Window must fit: win <= bin and bin + win <= 254
  assign hi_sum   = {1'b0, bin_q} + {{(BIN_W + 1 - WIN_W){1'b0}}, win_i};
  assign in_range = ({2'b00, win_i} <= bin_q) && (hi_sum <= (BIN_W + 1)'(LAST_CENTER));
  assign total    = in_range ? {win_i, 1'b0} : '0;
  assign nbr_off  = {{(BIN_W - STEP_W + 1){1'b0}}, step_q[STEP_W-1:1]} + BIN_W'(1);

  // Sequence center read, neighbor reads and compares
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    fail_d     = fail_q;
    nbr_pend_d = 1'b0;
    ctr_pend_d = 1'b0;
    rd_req_o   = '0;
    unique case (state_q)
      Q_IDLE: begin
        if (start_i) begin
          state_d = Q_CENTER;
        end
      end
      Q_CENTER: begin
        rd_req_o.en   = 1'b1;
        rd_req_o.addr = bin_q;
        ctr_pend_d    = 1'b1;
        step_d        = '0;
        fail_d        = 1'b0;
        state_d       = Q_NBR;
      end
      Q_NBR: begin
        if (nbr_pend_q && (rd_data_i <= center_q)) begin
          fail_d = 1'b1;
        end
        if (step_q != total) begin
          rd_req_o.en   = 1'b1;
          rd_req_o.addr = step_q[0] ? bin_q + nbr_off : bin_q - nbr_off;
          nbr_pend_d    = 1'b1;
          step_d        = step_q + 1'b1;
        end else if (!nbr_pend_q && !ctr_pend_q) begin
          state_d = Q_DONE;
        end
      end
      Q_DONE: begin
        if (take_i) begin
          state_d = Q_IDLE;
        end
      end
      default: begin
        state_d = Q_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= Q_IDLE;
      step_q     <= '0;
      fail_q     <= 1'b0;
      nbr_pend_q <= 1'b0;
      ctr_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      fail_q     <= fail_d;
      nbr_pend_q <= nbr_pend_d;
      ctr_pend_q <= ctr_pend_d;
    end
  end

  // Hold the queried bin and its count
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == Q_IDLE)) begin
      bin_q <= bin_i;
    end
    if (ctr_pend_q) begin
      center_q <= rd_data_i;
    end
  end

  assign busy_o          = (state_q != Q_IDLE);
  assign status_o.done   = (state_q == Q_DONE);
  assign status_o.valley = in_range && !fail_q;
  assign count_o         = center_q;

endmodule

### verif/tb_brightness_histogram_valley_finder_top.sv
// Testbench of the brightness histogram valley finder: a predictor of the
// bin counts and valley checks, stream and APB drivers, and a result checker.
// Depends on bhvf_pkg and brightness_histogram_valley_finder_top.
module tb_brightness_histogram_valley_finder_top;
  import bhvf_pkg::*;

  localparam int unsigned COUNT_W = COUNT_BITS_DEF;
  // Longest query (window 63) plus margin, in cycles
  localparam int unsigned DRAIN_CYCLES = 2 * 63 + 25;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam logic [2:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};

  typedef struct {
    logic [FIELD_W-1:0] bin_count;
    logic [FIELD_W-1:0] valley_value;
    logic               is_valley;
  } bin_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16], query_bin[31:24]
  logic [1:0]  s_axis_tuser = '0;   // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // bin_count[23:0], valley_value[47:24]
  logic        m_axis_tuser;        // is_valley[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: bin counts and window register
  logic [COUNT_W-1:0] tally [NUM_BINS];
  logic [WIN_W-1:0]   win_size = WIN_RESET;
  bin_report_t        pending_reports [$];
  bin_report_t        want_report;

  int idle_pct = 27;
  int mismatches = 0;
  int n_items = 0;
  int n_queries = 0;
  int n_valleys = 0;
  int n_windows = 0;

  brightness_histogram_valley_finder_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result side at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // Valley test on the predicted histogram
  function automatic logic valley_at(int b);
    int w;
    logic [COUNT_W-1:0] c;
    w = win_size;
    if (b < w || b + w > LAST_CENTER) return 1'b0;
    c = tally[b];
    for (int j = 1; j <= w; j++) begin
      if (tally[b - j] <= c || tally[b + j] <= c) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [FIELD_W-1:0] clip_count(logic [COUNT_W-1:0] c);
    if (COUNT_W > FIELD_W && c > {FIELD_W{1'b1}}) return {FIELD_W{1'b1}};
    return c[FIELD_W-1:0];
  endfunction

  // Apply one accepted item to the predicted histogram
  task automatic predict_item(input kind_e k, input logic [31:0] data);
    int b;
    bin_report_t rep;
    case (k)
      KIND_PIXEL: begin
        b = (int'(data[7:0]) + int'(data[15:8]) + int'(data[23:16])) / 3;
        if (tally[b] != {COUNT_W{1'b1}}) tally[b] = tally[b] + 1'b1;
      end
      KIND_QUERY: begin
        b = data[31:24];
        rep.is_valley = valley_at(b);
        rep.bin_count = clip_count(tally[b]);
        rep.valley_value = rep.is_valley ? rep.bin_count : '0;
        pending_reports = {pending_reports, rep};
      end
      KIND_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
  endtask

  // Check each result item against the oldest prediction, then predict
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_reports.size() == 0) begin
          flag_mismatch("unrequested result", '0, m_axis_tdata[23:0]);
        end else begin
          want_report = pending_reports.pop_front();
          if (m_axis_tdata[23:0] !== want_report.bin_count)
            flag_mismatch("bin_count", want_report.bin_count, m_axis_tdata[23:0]);
          if (m_axis_tdata[47:24] !== want_report.valley_value)
            flag_mismatch("valley_value", want_report.valley_value, m_axis_tdata[47:24]);
          if (m_axis_tuser !== want_report.is_valley)
            flag_mismatch("is_valley", FIELD_W'(want_report.is_valley),
                          FIELD_W'(m_axis_tuser));
          if (want_report.is_valley) n_valleys++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_item(kind_e'(s_axis_tuser), s_axis_tdata);
    end
  end

  // Offer one item with random gaps and hold it until taken; call at a falling edge
  task automatic send_item(input kind_e k, input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue, input logic [7:0] qbin);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {qbin, blue, green, red};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (k != KIND_NONE) n_items++;
    if (k == KIND_QUERY) n_queries++;
  endtask

  // Pick random channels whose mean floors to the given bin
  task automatic send_pixel(input int b);
    int s, lo, hi, r, g, rem;
    s = 3 * b + $urandom_range(0, 2);
    if (s > 765) s = 765;
    lo = (s > 510) ? s - 510 : 0;
    hi = (s > 255) ? 255 : s;
    r = $urandom_range(hi, lo);
    rem = s - r;
    lo = (rem > 255) ? rem - 255 : 0;
    hi = (rem > 255) ? 255 : rem;
    g = $urandom_range(hi, lo);
    send_item(KIND_PIXEL, 8'(r), 8'(g), 8'(rem - g), 8'($urandom));
  endtask

  task automatic send_query(input int b);
    if (b < 0) b = 0;
    if (b > 255) b = 255;
    send_item(KIND_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), 8'(b));
  endtask

  task automatic send_clear();
    send_item(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Mixed random item, unused kind included
  task automatic send_noise();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      send_item(KIND_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    else if (pick < 85) send_query($urandom_range(0, 255));
    else if (pick < 90) send_clear();
    else send_item(KIND_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Drain, write the window over APB, then read it back
  task automatic set_window(input int w);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WINDOW_ADDR;
    pwdata  <= {$urandom} & ~32'(6'h3f) | 32'(w[WIN_W-1:0]);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    win_size = w[WIN_W-1:0];
    n_windows++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[WIN_W-1:0] !== win_size)
      flag_mismatch("window readback", FIELD_W'(win_size), FIELD_W'(prdata[WIN_W-1:0]));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Shape a V around the center (sometimes with a tie), then query around it
  task automatic sculpt_valley(input int center);
    int w, lo, hi, base, tie_bin, n;
    w = win_size;
    if ($urandom_range(0, 4) != 0) send_clear();
    base = $urandom_range(0, 2);
    tie_bin = -10;
    if (w > 0 && $urandom_range(0, 4) == 0)
      tie_bin = center + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, w);
    lo = (center - w - 1 < 0) ? 0 : center - w - 1;
    hi = (center + w + 1 > 255) ? 255 : center + w + 1;
    for (int b = lo; b <= hi; b++) begin
      n = (b == center || b == tie_bin) ? base : base + 1 + $urandom_range(0, 1);
      repeat (n) send_pixel(b);
    end
    send_query(center);
    send_query(center + $urandom_range(0, 2) - 1);
  endtask

  // Empty histogram right after reset: nothing is a valley
  task automatic test_empty_histogram();
    send_query(0);
    send_query(255);
  endtask

  // Extreme channel values, the unused kind and valleys at both window edges
  task automatic test_edge_bins();
    send_item(KIND_PIXEL, 8'd0, 8'd0, 8'd0, 8'hff);
    send_item(KIND_PIXEL, 8'd1, 8'd1, 8'd0, 8'h00);
    send_item(KIND_PIXEL, 8'd255, 8'd255, 8'd255, 8'h00);
    send_item(KIND_PIXEL, 8'd255, 8'd255, 8'd254, 8'hff);
    send_item(KIND_PIXEL, 8'd2, 8'd2, 8'd2, 8'h55);
    send_item(KIND_PIXEL, 8'd252, 8'd252, 8'd252, 8'haa);
    send_item(KIND_NONE, 8'hff, 8'hff, 8'hff, 8'hff);
    set_window(1);
    send_query(1);
    send_query(253);
    send_query(254);
    send_query(0);
    send_query(2);
    send_clear();
    send_query(1);
    set_window(0);
    send_query(0);
    send_query(255);
  endtask

  // Smallest and largest windows with centers at the limits and, for the small windows, just past them
  task automatic test_window_sweep();
    int sizes [3];
    sizes = '{0, 1, 63};
    foreach (sizes[i]) begin
      set_window(sizes[i]);
      sculpt_valley(sizes[i]);
      sculpt_valley(254 - sizes[i]);
      if (sizes[i] < 8) begin
        sculpt_valley(sizes[i] - 1);
        sculpt_valley(255 - sizes[i]);
      end
    end
  endtask

  // Back-to-back traffic with neither side ever stalling
  task automatic test_full_rate();
    idle_pct = 0;
    set_window(3);
    repeat (4) sculpt_valley($urandom_range(3, 251));
    repeat (40) send_noise();
    idle_pct = 27;
  endtask

  // Random windows; mostly shaped valleys with random content, some noise
  task automatic test_random_mix();
    int w;
    while (n_items < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      set_window(w);
      repeat ($urandom_range(2, 5)) begin
        if (n_items >= RANDOM_ITEMS) break;
        if ($urandom_range(0, 99) < 70) sculpt_valley($urandom_range(0, 255));
        else repeat ($urandom_range(8, 25)) send_noise();
      end
    end
  endtask

  initial begin
    foreach (tally[i]) tally[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_histogram();
    test_edge_bins();
    test_window_sweep();
    test_full_rate();
    test_random_mix();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d items, %0d queries with %0d valleys, %0d window writes",
             n_items, n_queries, n_valleys, n_windows);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/bhvf_pkg.sv
rtl/bhvf_ram.sv
rtl/bhvf_store.sv
rtl/bhvf_query.sv
rtl/brightness_histogram_valley_finder_top.sv
verif/tb_brightness_histogram_valley_finder_top.sv
